// ===== src/trcs_pkg.sv =====
// shared types, constants and arithmetic helpers for the threshold reach city select block
package trcs_pkg;

   localparam int NODES       = 64;
   localparam int WEIGHT_BITS = 14;
   localparam int DIST_BITS   = 20;

   localparam int NODE_BITS   = $clog2(NODES);
   localparam int CNT_BITS    = $clog2(NODES);
   localparam int DEPTH       = NODES * NODES;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int WIDE_BITS   = (WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS;

   localparam int PORT_NODE_BITS = 6;
   localparam int LIMIT_BITS     = 20;
   localparam int TOTAL_BITS     = 7;
   localparam int CSR_DATA_BITS  = 20;
   localparam int CSR_INDEX_BITS = 1;
   localparam int OUT_MAX        = 63;

   typedef logic [DIST_BITS-1:0]      dist_type;
   typedef logic [NODE_BITS-1:0]      node_type;
   typedef logic [CNT_BITS-1:0]       cnt_type;
   typedef logic [ADDR_BITS-1:0]      addr_type;
   typedef logic [PORT_NODE_BITS-1:0] port_node_type;

   localparam dist_type INF_CODE  = {DIST_BITS{1'b1}};
   localparam node_type NODE_LAST = NODE_BITS'(NODES - 1);

   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REACH_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_TOTAL  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE1,
      ST_EDGE2,
      ST_PIVOT,
      ST_PIVWAIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_COUNT,
      ST_CDRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      dist_type wdata;
      addr_type raddr_a;
      addr_type raddr_b;
   } mem_req_type;

   function automatic addr_type cell_addr(node_type row, node_type col);
      return ADDR_BITS'(ADDR_BITS'(row) * ADDR_BITS'(NODES) + ADDR_BITS'(col));
   endfunction

   function automatic dist_type sat_add(dist_type a, dist_type b);
      logic [DIST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == INF_CODE || b == INF_CODE || s > {1'b0, INF_CODE})
         return INF_CODE;
      return DIST_BITS'(s);
   endfunction

   function automatic dist_type sat_weight(logic [WEIGHT_BITS-1:0] w);
      logic [WIDE_BITS-1:0] wx;
      wx = WIDE_BITS'(w);
      if (wx > WIDE_BITS'(INF_CODE))
         return INF_CODE;
      return DIST_BITS'(wx);
   endfunction

   function automatic node_type nodes_last(logic [TOTAL_BITS-1:0] total);
      if (total == '0)
         return '0;
      if (32'(total) > NODES)
         return NODE_LAST;
      return NODE_BITS'(total - TOTAL_BITS'(1));
   endfunction

   function automatic logic reachable(dist_type d, logic [LIMIT_BITS-1:0] limit);
      logic [63:0] dx;
      logic [63:0] lx;
      dx = 64'(d);
      lx = 64'(limit);
      return (d != INF_CODE) && (dx <= lx);
   endfunction

   function automatic port_node_type out_count(cnt_type c);
      logic [31:0] cx;
      cx = 32'(c);
      if (cx > OUT_MAX)
         return PORT_NODE_BITS'(OUT_MAX);
      return PORT_NODE_BITS'(cx);
   endfunction

endpackage

// ===== src/threshold_reach_city_select.sv =====
// top level: configuration registers, sequencer and distance store
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_stall    command, end_a, end_b, edge_weight
//   rsp      out        rsp_valid/rsp_stall    chosen_node, reach_count
//   csr      in         csr_write              csr_index, csr_data
//
// an edge beat reads its cell when taken, then writes once per direction of the pair
// (EDGE1, then EDGE2); a new edge is taken during the second write, in EDGE2
// a solve runs one relaxation sweep per pivot and row, then a counting pass over the
// cells in use and a load of the result, bound by the single write port of the store
// after reset and after each solve, a clearing pass writes all NODES*NODES cells of
// the store; req_stall is high during it
// a waiting result on a stalled rsp channel holds the solve in its last cycle
module threshold_reach_city_select
   import trcs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [PORT_NODE_BITS-1:0]  req_end_a,
   input  logic [PORT_NODE_BITS-1:0]  req_end_b,
   input  logic [WEIGHT_BITS-1:0]     req_edge_weight,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [PORT_NODE_BITS-1:0]  rsp_chosen_node,
   output logic [PORT_NODE_BITS-1:0]  rsp_reach_count,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data
);

   logic [LIMIT_BITS-1:0] reach_limit_ff;
   logic [TOTAL_BITS-1:0] node_total_ff;
   mem_req_type           mem_req;
   dist_type              rd_a;
   dist_type              rd_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_limit_ff <= '0;
         node_total_ff  <= TOTAL_BITS'(NODES);
      end else if (csr_write) begin
         case (csr_index)
            CSR_REACH_LIMIT: reach_limit_ff <= LIMIT_BITS'(csr_data);
            CSR_NODE_TOTAL:  node_total_ff  <= TOTAL_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   trcs_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_end_a       (req_end_a),
      .req_end_b       (req_end_b),
      .req_edge_weight (req_edge_weight),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chosen_node (rsp_chosen_node),
      .rsp_reach_count (rsp_reach_count),
      .reach_limit     (reach_limit_ff),
      .node_total      (node_total_ff),
      .mem_req         (mem_req),
      .rd_a            (rd_a),
      .rd_b            (rd_b)
   );

   trcs_dist_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

endmodule

// ===== src/trcs_dist_ram.sv =====
// distance store: one write port, two registered read ports
module trcs_dist_ram
   import trcs_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output dist_type    rd_a,
   output dist_type    rd_b
);

   dist_type mem [DEPTH];
   dist_type rd_a_ff;
   dist_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_a_ff <= mem[mem_req.raddr_a];
      rd_b_ff <= mem[mem_req.raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== src/trcs_seq.sv =====
// sequencer: edge loads, clearing pass, floyd-warshall sweep, threshold count and result beat
module trcs_seq
   import trcs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  port_node_type           req_end_a,
   input  port_node_type           req_end_b,
   input  logic [WEIGHT_BITS-1:0]  req_edge_weight,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output port_node_type           rsp_chosen_node,
   output port_node_type           rsp_reach_count,
   input  logic [LIMIT_BITS-1:0]   reach_limit,
   input  logic [TOTAL_BITS-1:0]   node_total,
   output mem_req_type             mem_req,
   input  dist_type                rd_a,
   input  dist_type                rd_b
);

   state_type     state_ff, state_in;
   node_type      row_ff, row_in;
   node_type      col_ff, col_in;
   node_type      piv_ff, piv_in;
   node_type      last_ff, last_in;
   dist_type      dik_ff, dik_in;
   node_type      e_a_ff, e_a_in;
   node_type      e_b_ff, e_b_in;
   dist_type      e_w_ff, e_w_in;
   logic          e_ok_ff, e_ok_in;
   logic          e_upd_ff, e_upd_in;
   logic          fwd_v_ff, fwd_v_in;
   dist_type      fwd_d_ff, fwd_d_in;
   logic          sw_v_ff, sw_v_in;
   addr_type      sw_addr_ff, sw_addr_in;
   logic          cnt_v_ff, cnt_v_in;
   logic          cnt_self_ff, cnt_self_in;
   logic          cnt_first_ff, cnt_first_in;
   logic          cnt_last_ff, cnt_last_in;
   node_type      cnt_row_ff, cnt_row_in;
   cnt_type       acc_ff, acc_in;
   cnt_type       best_cnt_ff, best_cnt_in;
   node_type      best_node_ff, best_node_in;
   logic          rsp_valid_ff, rsp_valid_in;
   port_node_type rsp_node_ff, rsp_node_in;
   port_node_type rsp_count_ff, rsp_count_in;

   logic     req_acc;
   logic     rsp_free;
   logic     new_ok;
   addr_type new_addr;
   dist_type via;
   dist_type cur_d;
   cnt_type  sum;

   assign req_stall = !(state_ff == ST_IDLE || state_ff == ST_EDGE2);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign new_ok    = (32'(req_end_a) < NODES) && (32'(req_end_b) < NODES)
                      && (req_end_a != req_end_b);
   assign new_addr  = new_ok ? cell_addr(NODE_BITS'(req_end_a), NODE_BITS'(req_end_b)) : '0;
   assign via       = sat_add(dik_ff, rd_a);
   assign cur_d     = fwd_v_ff ? fwd_d_ff : rd_a;
   assign sum       = (cnt_first_ff ? '0 : acc_ff)
                      + CNT_BITS'(!cnt_self_ff && reachable(rd_b, reach_limit));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (row_ff == NODE_LAST && col_ff == NODE_LAST) state_in = ST_IDLE;
         end
         ST_IDLE, ST_EDGE2: begin
            if (req_acc) begin
               state_in = (req_command == CMD_EDGE) ? ST_EDGE1 : ST_PIVOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE1:   state_in = ST_EDGE2;
         ST_PIVOT:   state_in = ST_PIVWAIT;
         ST_PIVWAIT: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (col_ff == last_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (row_ff == last_ff && piv_ff == last_ff) state_in = ST_COUNT;
            else state_in = ST_PIVOT;
         end
         ST_COUNT: begin
            if (row_ff == last_ff && col_ff == last_ff) state_in = ST_CDRAIN;
         end
         ST_CDRAIN:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) state_in = ST_CLEAR;
         end
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      piv_in       = piv_ff;
      last_in      = last_ff;
      dik_in       = dik_ff;
      e_a_in       = e_a_ff;
      e_b_in       = e_b_ff;
      e_w_in       = e_w_ff;
      e_ok_in      = e_ok_ff;
      e_upd_in     = e_upd_ff;
      fwd_v_in     = 1'b0;
      fwd_d_in     = fwd_d_ff;
      sw_v_in      = 1'b0;
      sw_addr_in   = sw_addr_ff;
      cnt_v_in     = 1'b0;
      cnt_self_in  = cnt_self_ff;
      cnt_first_in = cnt_first_ff;
      cnt_last_in  = cnt_last_ff;
      cnt_row_in   = cnt_row_ff;
      acc_in       = acc_ff;
      best_cnt_in  = best_cnt_ff;
      best_node_in = best_node_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_count_in = rsp_count_ff;
      mem_req      = '0;

      // relaxation stage
      if (sw_v_ff && via < rd_b) begin
         mem_req.we    = 1'b1;
         mem_req.waddr = sw_addr_ff;
         mem_req.wdata = via;
      end

      // count stage
      if (cnt_v_ff) begin
         acc_in = sum;
         if (cnt_last_ff && (cnt_row_ff == '0 || sum <= best_cnt_ff)) begin
            best_cnt_in  = sum;
            best_node_in = cnt_row_ff;
         end
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cell_addr(row_ff, col_ff);
            mem_req.wdata = (row_ff == col_ff) ? '0 : INF_CODE;
            if (col_ff == NODE_LAST) begin
               col_in = '0;
               row_in = (row_ff == NODE_LAST) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_IDLE, ST_EDGE2: begin
            if (state_ff == ST_EDGE2 && e_upd_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cell_addr(e_b_ff, e_a_ff);
               mem_req.wdata = e_w_ff;
            end
            if (req_acc) begin
               if (req_command == CMD_EDGE) begin
                  e_a_in          = NODE_BITS'(req_end_a);
                  e_b_in          = NODE_BITS'(req_end_b);
                  e_w_in          = sat_weight(req_edge_weight);
                  e_ok_in         = new_ok;
                  mem_req.raddr_a = new_addr;
                  fwd_v_in        = (state_ff == ST_EDGE2) && e_upd_ff
                                    && (new_addr == cell_addr(e_b_ff, e_a_ff));
                  fwd_d_in        = e_w_ff;
               end else begin
                  last_in = nodes_last(node_total);
                  row_in  = '0;
                  col_in  = '0;
                  piv_in  = '0;
               end
            end
         end
         ST_EDGE1: begin
            e_upd_in = e_ok_ff && (e_w_ff < cur_d);
            if (e_ok_ff && e_w_ff < cur_d) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cell_addr(e_a_ff, e_b_ff);
               mem_req.wdata = e_w_ff;
            end
         end
         ST_PIVOT: begin
            mem_req.raddr_a = cell_addr(row_ff, piv_ff);
         end
         ST_PIVWAIT: begin
            dik_in = rd_a;
            col_in = '0;
         end
         ST_SWEEP: begin
            mem_req.raddr_a = cell_addr(piv_ff, col_ff);
            mem_req.raddr_b = cell_addr(row_ff, col_ff);
            sw_v_in         = 1'b1;
            sw_addr_in      = cell_addr(row_ff, col_ff);
            col_in          = (col_ff == last_ff) ? '0 : col_ff + 1'b1;
         end
         ST_DRAIN: begin
            col_in = '0;
            if (row_ff == last_ff) begin
               row_in = '0;
               if (piv_ff != last_ff) piv_in = piv_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_COUNT: begin
            mem_req.raddr_b = cell_addr(row_ff, col_ff);
            cnt_v_in        = 1'b1;
            cnt_self_in     = (row_ff == col_ff);
            cnt_first_in    = (col_ff == '0);
            cnt_last_in     = (col_ff == last_ff);
            cnt_row_in      = row_ff;
            if (col_ff == last_ff) begin
               col_in = '0;
               if (row_ff != last_ff) row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_CDRAIN: begin
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = PORT_NODE_BITS'(best_node_ff);
               rsp_count_in = out_count(best_cnt_ff);
               row_in       = '0;
               col_in       = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         piv_ff       <= '0;
         last_ff      <= '0;
         e_ok_ff      <= 1'b0;
         e_upd_ff     <= 1'b0;
         fwd_v_ff     <= 1'b0;
         sw_v_ff      <= 1'b0;
         cnt_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         piv_ff       <= piv_in;
         last_ff      <= last_in;
         e_ok_ff      <= e_ok_in;
         e_upd_ff     <= e_upd_in;
         fwd_v_ff     <= fwd_v_in;
         sw_v_ff      <= sw_v_in;
         cnt_v_ff     <= cnt_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dik_ff       <= dik_in;
      e_a_ff       <= e_a_in;
      e_b_ff       <= e_b_in;
      e_w_ff       <= e_w_in;
      fwd_d_ff     <= fwd_d_in;
      sw_addr_ff   <= sw_addr_in;
      cnt_self_ff  <= cnt_self_in;
      cnt_first_ff <= cnt_first_in;
      cnt_last_ff  <= cnt_last_in;
      cnt_row_ff   <= cnt_row_in;
      acc_ff       <= acc_in;
      best_cnt_ff  <= best_cnt_in;
      best_node_ff <= best_node_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_node = rsp_node_ff;
   assign rsp_reach_count = rsp_count_ff;

endmodule

// ===== src/trcs_checker.sv =====
// port-level checks for the threshold reach city select block and its bind
module trcs_checker
   import trcs_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_command,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [PORT_NODE_BITS-1:0]  rsp_chosen_node,
   input logic [PORT_NODE_BITS-1:0]  rsp_reach_count
);

   // clearing pass follows reset
   assert property (@(posedge clock) reset |=> req_stall && !rsp_valid)
      else $error("input not held or result shown after reset");

   // edge beat: busy in EDGE1, then open again in EDGE2
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_EDGE |=> req_stall ##1 !req_stall)
      else $error("edge beat timing wrong");

   // a solve beat keeps the input closed
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_SOLVE |=> req_stall ##1 req_stall)
      else $error("input open during solve");

   // a stalled result beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chosen_node)
      && $stable(rsp_reach_count))
      else $error("stalled result beat changed");

endmodule

bind threshold_reach_city_select trcs_checker u_checker (.*);
